// File: hw/rtl/btee_pkg.sv
// Package for the balanced tree ensemble evaluator.
// Sizes, command codes, sequencer states and saturation helper. No dependencies.
package btee_pkg;
  localparam int MaxNodes    = 1024;
  localparam int MaxLeaves   = 1024;
  localparam int MaxTrees    = 64;
  localparam int MaxFeatures = 256;
  localparam int MaxDepth    = 16;

  localparam int NodeAw = $clog2(MaxNodes);
  localparam int LeafAw = $clog2(MaxLeaves);
  localparam int TreeAw = $clog2(MaxTrees);
  localparam int FeatAw = $clog2(MaxFeatures);
  localparam int NodeW  = 8 + 32 + 10 + 10;

  localparam logic [1:0] CMD_NODE = 2'd0;
  localparam logic [1:0] CMD_LEAF = 2'd1;
  localparam logic [1:0] CMD_ROOT = 2'd2;
  localparam logic [1:0] CMD_FEAT = 2'd3;

  localparam logic [1:0] REG_TREE_TOTAL    = 2'd0;
  localparam logic [1:0] REG_TREE_DEPTH    = 2'd1;
  localparam logic [1:0] REG_BASE_SCORE    = 2'd2;
  localparam logic [1:0] REG_FEATURE_TOTAL = 2'd3;

  localparam logic signed [47:0] ScoreMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ScoreMin = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROOT, ST_NODE, ST_FEAT, ST_STEP, ST_LEAF, ST_ADD, ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]         feat;
    logic signed [31:0] split;
    logic [9:0]         tchild;
    logic [9:0]         fchild;
  } node_t;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [31:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {{17{b[31]}}, b};
    if (s > $signed({1'b0, ScoreMax})) return ScoreMax;
    if (s < $signed({1'b1, ScoreMin})) return ScoreMin;
    return s[47:0];
  endfunction
endpackage

// File: hw/rtl/balanced_tree_ensemble_eval_unit.sv
// Balanced decision tree ensemble evaluator, top level.
// Operation: load words are accepted without a stall; a row-closing feature word starts a walk of
// each tree (root, then node, feature and step per level, then leaf and add) through one node port.
// Throughput: one word at a time; in_stall is high while a row is walked or a score waits.
// Reset (rst_n, synchronous): config to defaults, sequencer idle, memories undefined.
module balanced_tree_ensemble_eval_unit
  import btee_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [9:0]         in_slot,
  input  logic signed [31:0] in_datum,
  input  logic [7:0]         in_feature_pick,
  input  logic [9:0]         in_child_if_true,
  input  logic [9:0]         in_child_if_false,
  input  logic               in_row_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_score
);
  logic [6:0]         tree_total_r;
  logic [4:0]         tree_depth_r;
  logic signed [31:0] base_score_r;
  logic [8:0]         feature_total_r;

  state_t state_r, state_nxt;
  logic [TreeAw:0]    tree_r, tree_nxt;
  logic [4:0]         lvl_r, lvl_nxt;
  logic [9:0]         node_r, node_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic               nvalid_r, nvalid_nxt;
  logic               fvalid_r, fvalid_nxt;

  logic [6:0] trees;
  logic [4:0] depth;
  logic       acc_in;
  node_t      node_wd, node_rd;
  logic signed [31:0] leaf_rd, feat_rd;
  logic [9:0] root_rd;
  logic       leaf_ok;

  assign trees = (tree_total_r > 7'(MaxTrees)) ? 7'(MaxTrees) : tree_total_r;
  assign depth = (tree_depth_r > 5'(MaxDepth)) ? 5'(MaxDepth) : tree_depth_r;
  assign in_stall = (state_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DONE);
  assign out_score = acc_r;
  assign node_wd = '{feat: in_feature_pick, split: in_datum,
                     tchild: in_child_if_true, fchild: in_child_if_false};
  assign leaf_ok = ({22'd0, node_r} < 32'(MaxLeaves));

  btee_store u_store (
    .clk     (clk),
    .node_we (acc_in && in_cmd == CMD_NODE && {22'd0, in_slot} < 32'(MaxNodes)),
    .node_wa (in_slot[NodeAw-1:0]),
    .node_wd (node_wd),
    .node_ra (node_r[NodeAw-1:0]),
    .node_rd (node_rd),
    .leaf_we (acc_in && in_cmd == CMD_LEAF && {22'd0, in_slot} < 32'(MaxLeaves)),
    .leaf_wa (in_slot[LeafAw-1:0]),
    .leaf_wd (in_datum),
    .leaf_ra (node_r[LeafAw-1:0]),
    .leaf_rd (leaf_rd),
    .root_we (acc_in && in_cmd == CMD_ROOT && {22'd0, in_slot} < 32'(MaxTrees)),
    .root_wa (in_slot[TreeAw-1:0]),
    .root_wd (in_child_if_true),
    .root_ra (tree_nxt[TreeAw-1:0]),
    .root_rd (root_rd),
    .feat_we (acc_in && in_cmd == CMD_FEAT && {1'b0, in_slot} < {2'b0, feature_total_r}
              && {22'd0, in_slot} < 32'(MaxFeatures)),
    .feat_wa (in_slot[FeatAw-1:0]),
    .feat_wd (in_datum),
    .feat_ra (node_rd.feat[FeatAw-1:0]),
    .feat_rd (feat_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_total_r    <= '0;
      tree_depth_r    <= '0;
      base_score_r    <= '0;
      feature_total_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TREE_TOTAL:    tree_total_r    <= cfg_data[6:0];
        REG_TREE_DEPTH:    tree_depth_r    <= cfg_data[4:0];
        REG_BASE_SCORE:    base_score_r    <= cfg_data;
        REG_FEATURE_TOTAL: feature_total_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc_in && in_cmd == CMD_FEAT && in_row_last) begin
        state_nxt = (trees == 7'd0) ? ST_DONE : ST_ROOT;
      end
      ST_ROOT: state_nxt = (depth == 5'd0) ? ST_LEAF : ST_NODE;
      ST_NODE: state_nxt = ST_FEAT;
      ST_FEAT: state_nxt = ST_STEP;
      ST_STEP: state_nxt = (lvl_r + 5'd1 == depth) ? ST_LEAF : ST_NODE;
      ST_LEAF: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = (7'(tree_r) + 7'd1 == trees) ? ST_DONE : ST_ROOT;
      ST_DONE: if (!out_stall) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tree_nxt   = tree_r;
    lvl_nxt    = lvl_r;
    node_nxt   = node_r;
    acc_nxt    = acc_r;
    nvalid_nxt = nvalid_r;
    fvalid_nxt = fvalid_r;
    unique case (state_r)
      ST_IDLE: begin
        tree_nxt = '0;
        acc_nxt  = {{16{base_score_r[31]}}, base_score_r};
      end
      ST_ROOT: begin
        node_nxt = root_rd;
        lvl_nxt  = '0;
      end
      ST_NODE: nvalid_nxt = ({22'd0, node_r} < 32'(MaxNodes));
      ST_FEAT: fvalid_nxt = ({24'd0, node_rd.feat} < 32'(MaxFeatures));
      ST_STEP: begin
        if (!nvalid_r) node_nxt = '0;
        else if ((fvalid_r ? feat_rd : 32'sd0) <= node_rd.split) node_nxt = node_rd.tchild;
        else node_nxt = node_rd.fchild;
        lvl_nxt = lvl_r + 5'd1;
      end
      ST_LEAF: ;
      ST_ADD: begin
        if (leaf_ok) acc_nxt = sat_add(acc_r, leaf_rd);
        tree_nxt = tree_r + 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
    tree_r   <= tree_nxt;
    lvl_r    <= lvl_nxt;
    node_r   <= node_nxt;
    nvalid_r <= nvalid_nxt;
    fvalid_r <= fvalid_nxt;
  end
endmodule

// File: hw/rtl/btee_store.sv
// Node, leaf, root and feature memories with registered reads.
// Depends on btee_pkg.
module btee_store
  import btee_pkg::*;
(
  input  logic                clk,
  input  logic                node_we,
  input  logic [NodeAw-1:0]   node_wa,
  input  node_t               node_wd,
  input  logic [NodeAw-1:0]   node_ra,
  output node_t               node_rd,
  input  logic                leaf_we,
  input  logic [LeafAw-1:0]   leaf_wa,
  input  logic signed [31:0]  leaf_wd,
  input  logic [LeafAw-1:0]   leaf_ra,
  output logic signed [31:0]  leaf_rd,
  input  logic                root_we,
  input  logic [TreeAw-1:0]   root_wa,
  input  logic [9:0]          root_wd,
  input  logic [TreeAw-1:0]   root_ra,
  output logic [9:0]          root_rd,
  input  logic                feat_we,
  input  logic [FeatAw-1:0]   feat_wa,
  input  logic signed [31:0]  feat_wd,
  input  logic [FeatAw-1:0]   feat_ra,
  output logic signed [31:0]  feat_rd
);
  node_t              node_mem [MaxNodes];
  logic signed [31:0] leaf_mem [MaxLeaves];
  logic [9:0]         root_mem [MaxTrees];
  logic signed [31:0] feat_mem [MaxFeatures];

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    leaf_rd <= leaf_mem[leaf_ra];
  end
  always_ff @(posedge clk) begin
    if (root_we) root_mem[root_wa] <= root_wd;
    root_rd <= root_mem[root_ra];
  end
  always_ff @(posedge clk) begin
    if (feat_we) feat_mem[feat_wa] <= feat_wd;
    feat_rd <= feat_mem[feat_ra];
  end
endmodule

// File: hw/rtl/btee_checker.sv
// Port-level checks for the ensemble evaluator.
// Depends on btee_pkg and balanced_tree_ensemble_eval_unit; bound below.
module btee_checker
  import btee_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_cmd,
  input logic               in_row_last,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_score
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score)) else $error("score dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with score pending");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !(in_cmd == CMD_FEAT && in_row_last) |=> !in_stall)
    else $error("load word stalled");
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("score without row");
endmodule

bind balanced_tree_ensemble_eval_unit btee_checker u_btee_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
  .in_row_last(in_row_last), .out_valid(out_valid), .out_stall(out_stall),
  .out_score(out_score)
);
